@@ hw/rtl/psa_pkg.sv @@
// Package for the pressure sample averager: widths, register codes and reset values.
// Used by the interfaces and by every module of the block but psa_ram; depends on nothing.
`timescale 1ns / 1ps

package psa_pkg;

    // Number of samples averaged; the design supports 2 to 64.
    localparam int WINDOW_SAMPLES = 8;

    // Field widths fixed by the interface.
    localparam int MV_W       = 12;
    localparam int SCALE_W    = 20;
    localparam int PRESSURE_W = 16;
    localparam int CFG_DATA_W = 20;
    localparam int REG_IDX_W  = 2;

    // Derived datapath widths.
    localparam int PROD_W  = MV_W + SCALE_W;
    localparam int DIFF_W  = PRESSURE_W + 3;
    localparam int POS_W   = $clog2(WINDOW_SAMPLES);
    localparam int COUNT_W = $clog2(WINDOW_SAMPLES + 1);
    localparam int SUM_W   = PRESSURE_W + POS_W;
    localparam int STEP_W  = $clog2(SUM_W);

    // Sample queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register reset values.
    localparam logic [SCALE_W-1:0]           SCALE_RESET     = SCALE_W'(59652);
    localparam logic signed [PRESSURE_W-1:0] INTERCEPT_RESET = PRESSURE_W'(114);
    localparam logic signed [PRESSURE_W-1:0] ZERO_RESET      = '0;

    // Saturation limits of a converted sample.
    localparam logic signed [DIFF_W-1:0] SAT_MAX = DIFF_W'(32767);
    localparam logic signed [DIFF_W-1:0] SAT_MIN = -DIFF_W'(32768);

    // Configuration register indexes.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_SCALE     = 2'd0,
        REG_INTERCEPT = 2'd1,
        REG_ZERO      = 2'd2
    } reg_index_t;

endpackage

@@ hw/rtl/psa_if.sv @@
// Handshake interfaces of the pressure sample averager: input, result and configuration.
// Depends on psa_pkg for field widths.
`timescale 1ns / 1ps

// Input word: one converter reading.
interface psa_in_if;
    logic                         valid;
    logic                         ready;
    logic [psa_pkg::MV_W-1:0]     raw_millivolts;

    modport source (output valid, output raw_millivolts, input ready);
    modport sink   (input valid, input raw_millivolts, output ready);
endinterface

// Result word: averaged pressure and window status.
interface psa_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [psa_pkg::PRESSURE_W-1:0] filtered_pressure;
    logic                                window_full;

    modport source (output valid, output filtered_pressure, output window_full, input ready);
    modport sink   (input valid, input filtered_pressure, input window_full, output ready);
endinterface

// Configuration write word: register index and data.
interface psa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [psa_pkg::REG_IDX_W-1:0]   index;
    logic [psa_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/psa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stands alone; used for the sample ring.
`timescale 1ns / 1ps

module psa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/psa_queue.sv @@
// Short sample queue that decouples the conversion front end from the averaging back end.
// Depends on psa_pkg for depth and widths.
`timescale 1ns / 1ps

module psa_queue (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    input  logic signed [psa_pkg::PRESSURE_W-1:0]  push_sample,
    output logic                                   full,
    input  logic                                   pop,
    output logic signed [psa_pkg::PRESSURE_W-1:0]  head_sample,
    output logic                                   empty
);

    logic signed [psa_pkg::PRESSURE_W-1:0] entry_reg [psa_pkg::QUEUE_DEPTH];
    logic [psa_pkg::QPTR_W-1:0]            wr_ptr_reg;
    logic [psa_pkg::QPTR_W-1:0]            wr_ptr_next;
    logic [psa_pkg::QPTR_W-1:0]            rd_ptr_reg;
    logic [psa_pkg::QPTR_W-1:0]            rd_ptr_next;
    logic [psa_pkg::QCNT_W-1:0]            count_reg;
    logic [psa_pkg::QCNT_W-1:0]            count_next;

    assign full        = (count_reg == psa_pkg::QCNT_W'(psa_pkg::QUEUE_DEPTH));
    assign empty       = (count_reg == '0);
    assign head_sample = entry_reg[rd_ptr_reg];

    // Pointer and fill count update; the depth is a power of two so pointers wrap freely.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_sample;
        end
    end

endmodule

@@ hw/rtl/psa_front.sv @@
// Front end: configuration registers, input acceptance and millivolt to Q8.8 kPa conversion.
// Depends on psa_pkg and the interfaces in psa_if.
`timescale 1ns / 1ps

module psa_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    psa_in_if.sink                                 samples,
    psa_cfg_if.sink                                cfg,
    output logic                                   push,
    output logic signed [psa_pkg::PRESSURE_W-1:0]  push_sample,
    input  logic                                   queue_full
);

    logic [psa_pkg::SCALE_W-1:0]           scale_reg;
    logic signed [psa_pkg::PRESSURE_W-1:0] intercept_reg;
    logic signed [psa_pkg::PRESSURE_W-1:0] zero_reg;

    logic                        prod_valid_reg;
    logic                        prod_valid_next;
    logic [psa_pkg::PROD_W-1:0]  prod_reg;
    logic                        accept;

    logic [psa_pkg::PRESSURE_W-1:0]    scaled;
    logic signed [psa_pkg::DIFF_W-1:0] diff;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= psa_pkg::SCALE_RESET;
            intercept_reg <= psa_pkg::INTERCEPT_RESET;
            zero_reg      <= psa_pkg::ZERO_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                psa_pkg::REG_SCALE:
                begin
                    scale_reg <= cfg.data[psa_pkg::SCALE_W-1:0];
                end
                psa_pkg::REG_INTERCEPT:
                begin
                    intercept_reg <= $signed(cfg.data[psa_pkg::PRESSURE_W-1:0]);
                end
                psa_pkg::REG_ZERO:
                begin
                    zero_reg <= $signed(cfg.data[psa_pkg::PRESSURE_W-1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    // The product stage frees up whenever its word moves into the queue.
    assign push          = prod_valid_reg && !queue_full;
    assign samples.ready = !prod_valid_reg || !queue_full;
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        prod_valid_next = prod_valid_reg;
        if (accept)
        begin
            prod_valid_next = 1'b1;
        end
        else if (push)
        begin
            prod_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
        end
    end

    // Unsigned product of reading and scale, registered before the offset stage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg <= {{psa_pkg::SCALE_W{1'b0}}, samples.raw_millivolts}
                      * {{psa_pkg::MV_W{1'b0}}, scale_reg};
        end
    end

    // Drop the 16 fraction bits, subtract intercept and zero, then saturate.
    assign scaled = prod_reg[psa_pkg::PROD_W-1:psa_pkg::PROD_W-psa_pkg::PRESSURE_W];
    assign diff   = $signed({3'b000, scaled})
                  - $signed({{3{intercept_reg[psa_pkg::PRESSURE_W-1]}}, intercept_reg})
                  - $signed({{3{zero_reg[psa_pkg::PRESSURE_W-1]}}, zero_reg});

    always_comb
    begin
        if (diff > psa_pkg::SAT_MAX)
        begin
            push_sample = psa_pkg::SAT_MAX[psa_pkg::PRESSURE_W-1:0];
        end
        else if (diff < psa_pkg::SAT_MIN)
        begin
            push_sample = psa_pkg::SAT_MIN[psa_pkg::PRESSURE_W-1:0];
        end
        else
        begin
            push_sample = diff[psa_pkg::PRESSURE_W-1:0];
        end
    end

endmodule

@@ hw/rtl/psa_back.sv @@
// Back end: sample ring, running sum, bit-serial divide by the sample count and result register.
// Depends on psa_pkg, psa_ram and the result interface in psa_if.
`timescale 1ns / 1ps

module psa_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   empty,
    input  logic signed [psa_pkg::PRESSURE_W-1:0]  head_sample,
    output logic                                   pop,
    psa_out_if.source                              averages
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [psa_pkg::POS_W-1:0]              pos_reg;
    logic [psa_pkg::POS_W-1:0]              pos_next;
    logic                                   filled_reg;
    logic                                   filled_next;
    logic signed [psa_pkg::SUM_W-1:0]       sum_reg;
    logic signed [psa_pkg::SUM_W-1:0]       sum_next;
    logic signed [psa_pkg::PRESSURE_W-1:0]  sample_reg;
    logic signed [psa_pkg::PRESSURE_W-1:0]  sample_next;

    logic [psa_pkg::COUNT_W-1:0]  divisor_reg;
    logic [psa_pkg::COUNT_W-1:0]  divisor_next;
    logic [psa_pkg::COUNT_W-1:0]  rem_reg;
    logic [psa_pkg::COUNT_W-1:0]  rem_next;
    logic [psa_pkg::SUM_W-1:0]    quo_reg;
    logic [psa_pkg::SUM_W-1:0]    quo_next;
    logic [psa_pkg::STEP_W-1:0]   step_reg;
    logic [psa_pkg::STEP_W-1:0]   step_next;
    logic                         neg_reg;
    logic                         neg_next;

    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic signed [psa_pkg::PRESSURE_W-1:0]  out_pressure_reg;
    logic signed [psa_pkg::PRESSURE_W-1:0]  out_pressure_next;
    logic                                   out_full_reg;
    logic                                   out_full_next;

    logic                                   ring_we;
    logic [psa_pkg::PRESSURE_W-1:0]         ring_rdata;
    logic signed [psa_pkg::SUM_W-1:0]       old_ext;
    logic signed [psa_pkg::SUM_W-1:0]       new_ext;
    logic signed [psa_pkg::SUM_W-1:0]       sum_upd;
    logic                                   last_pos;
    logic [psa_pkg::COUNT_W:0]              shifted;
    logic                                   fits;
    logic [psa_pkg::SUM_W-1:0]              quo_signed;

    // Sample ring; the entry at the write position is read ahead of its overwrite.
    psa_ram #(
        .WIDTH (psa_pkg::PRESSURE_W),
        .DEPTH (psa_pkg::WINDOW_SAMPLES)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .raddr (pos_reg),
        .rdata (ring_rdata)
    );

    // Running sum update: drop the evicted entry once the ring is full, add the new one.
    assign old_ext  = filled_reg
                    ? {{psa_pkg::POS_W{ring_rdata[psa_pkg::PRESSURE_W-1]}}, ring_rdata}
                    : '0;
    assign new_ext  = {{psa_pkg::POS_W{sample_reg[psa_pkg::PRESSURE_W-1]}}, sample_reg};
    assign sum_upd  = sum_reg - old_ext + new_ext;
    assign last_pos = (pos_reg == psa_pkg::POS_W'(psa_pkg::WINDOW_SAMPLES - 1));
    assign ring_we  = (state_reg == ST_UPDATE);

    // One restoring divide step on the magnitude of the sum.
    assign shifted    = {rem_reg, quo_reg[psa_pkg::SUM_W-1]};
    assign fits       = (shifted >= {1'b0, divisor_reg});
    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    assign pop                        = (state_reg == ST_IDLE) && !empty;
    assign averages.valid             = out_valid_reg;
    assign averages.filtered_pressure = out_pressure_reg;
    assign averages.window_full       = out_full_reg;

    always_comb
    begin
        state_next        = state_reg;
        pos_next          = pos_reg;
        filled_next       = filled_reg;
        sum_next          = sum_reg;
        sample_next       = sample_reg;
        divisor_next      = divisor_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        step_next         = step_reg;
        neg_next          = neg_reg;
        out_valid_next    = out_valid_reg;
        out_pressure_next = out_pressure_reg;
        out_full_next     = out_full_reg;

        // The result register empties as soon as the consumer takes the word.
        if (out_valid_reg && averages.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    sample_next = head_sample;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                sum_next    = sum_upd;
                pos_next    = last_pos ? '0 : pos_reg + 1'b1;
                filled_next = filled_reg || last_pos;
                if (filled_reg || last_pos)
                begin
                    divisor_next = psa_pkg::COUNT_W'(psa_pkg::WINDOW_SAMPLES);
                end
                else
                begin
                    divisor_next = psa_pkg::COUNT_W'(pos_reg) + 1'b1;
                end
                neg_next   = sum_upd[psa_pkg::SUM_W-1];
                quo_next   = sum_upd[psa_pkg::SUM_W-1] ? (~sum_upd + 1'b1) : sum_upd;
                rem_next   = '0;
                step_next  = psa_pkg::STEP_W'(psa_pkg::SUM_W - 1);
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                rem_next  = fits ? shifted[psa_pkg::COUNT_W-1:0] - divisor_reg
                                 : shifted[psa_pkg::COUNT_W-1:0];
                quo_next  = {quo_reg[psa_pkg::SUM_W-2:0], fits};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || averages.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_pressure_next = quo_signed[psa_pkg::PRESSURE_W-1:0];
                    out_full_next     = filled_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, window bookkeeping and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pos_reg          <= '0;
            filled_reg       <= 1'b0;
            sum_reg          <= '0;
            out_valid_reg    <= 1'b0;
            out_pressure_reg <= '0;
            out_full_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pos_reg          <= pos_next;
            filled_reg       <= filled_next;
            sum_reg          <= sum_next;
            out_valid_reg    <= out_valid_next;
            out_pressure_reg <= out_pressure_next;
            out_full_reg     <= out_full_next;
        end
    end

    // Divider and sample datapath.
    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
        neg_reg     <= neg_next;
    end

endmodule

@@ hw/rtl/pressure_sample_averager_unit.sv @@
// Pressure sample averager top level: front end, sample queue and back end.
// Depends on psa_pkg, psa_if, psa_front, psa_queue, psa_back and psa_ram.
//
// Each accepted millivolt reading is scaled to signed Q8.8 kPa, offset by the intercept and
// zero registers, saturated to 16 bits and averaged over the last WINDOW_SAMPLES samples
// (fewer until the window has filled); one result word follows every input word. The front
// end takes a reading in any cycle its product stage is free or passing its word on, and
// hands it through the registered product stage to a two-entry queue. The back end takes
// one sample at a time from the queue, through update, a one-bit-per-cycle restoring divide
// and a finish step that waits for the result register to be free. Configuration writes are
// taken every cycle and must only be issued while no word is in flight.
`timescale 1ns / 1ps

module pressure_sample_averager_unit (
    input  logic        clk,
    input  logic        rst_n,
    psa_in_if.sink      samples,
    psa_cfg_if.sink     cfg,
    psa_out_if.source   averages
);

    logic                                   push;
    logic signed [psa_pkg::PRESSURE_W-1:0]  push_sample;
    logic                                   queue_full;
    logic                                   pop;
    logic signed [psa_pkg::PRESSURE_W-1:0]  head_sample;
    logic                                   queue_empty;

    // Conversion and register file.
    psa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples),
        .cfg         (cfg),
        .push        (push),
        .push_sample (push_sample),
        .queue_full  (queue_full)
    );

    // Decoupling queue of converted samples.
    psa_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_sample (push_sample),
        .full        (queue_full),
        .pop         (pop),
        .head_sample (head_sample),
        .empty       (queue_empty)
    );

    // Window, sum and averaging divide.
    psa_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (queue_empty),
        .head_sample (head_sample),
        .pop         (pop),
        .averages    (averages)
    );

endmodule

@@ bench/psa_average_checker.sv @@
// Scoreboard for the pressure sample averager: watches the reading, configuration and
// average channels, predicts every average word and compares it. Depends on psa_pkg, psa_if.
`timescale 1ns / 1ps

module psa_average_checker (
    input  logic clk,
    input  logic rst_n,
    psa_in_if    samples,
    psa_cfg_if   cfg,
    psa_out_if   averages,
    output int   fail_count,
    output int   pending,
    output int   results_checked,
    output int   clipped_samples
);
    import psa_pkg::*;

    localparam longint KPA_MAX      = 32767;
    localparam longint KPA_MIN      = -32768;
    localparam int     REPORT_LIMIT = 40;

    typedef struct packed {
        logic signed [PRESSURE_W-1:0] pressure;
        logic                         full;
    } average_word_t;

    // Shadow copy of the conversion registers.
    logic [SCALE_W-1:0]           scale_q;
    logic signed [PRESSURE_W-1:0] intercept_q;
    logic signed [PRESSURE_W-1:0] zero_q;

    // Shadow copy of the averaging window.
    logic signed [PRESSURE_W-1:0] window_ring [WINDOW_SAMPLES];
    int                           next_slot;
    bit                           window_filled;
    int                           window_sum;

    average_word_t expected_averages [$];
    average_word_t oldest;
    int            mismatches = 0;
    int            compared   = 0;
    int            clipped    = 0;

    assign fail_count      = mismatches;
    assign results_checked = compared;
    assign clipped_samples = clipped;

    // Converts one reading, pushes it into the window and queues the average it yields.
    task automatic record_sample(input logic [MV_W-1:0] mv);
        longint                       kpa;
        logic signed [PRESSURE_W-1:0] kpa_sat;
        int                           count;
        average_word_t                word;
        kpa = (longint'(mv) * longint'(scale_q)) >> 16;
        kpa = kpa - intercept_q - zero_q;
        if (kpa > KPA_MAX) begin
            kpa = KPA_MAX;
            clipped++;
        end else if (kpa < KPA_MIN) begin
            kpa = KPA_MIN;
            clipped++;
        end
        kpa_sat = kpa[PRESSURE_W-1:0];

        // Once the window is full the oldest sample leaves the sum first.
        if (window_filled)
            window_sum -= window_ring[next_slot];
        window_ring[next_slot] = kpa_sat;
        window_sum += kpa_sat;
        next_slot++;
        if (next_slot == WINDOW_SAMPLES) begin
            next_slot     = 0;
            window_filled = 1'b1;
        end

        // Integer division truncates toward zero, as the block's divider does.
        count         = window_filled ? WINDOW_SAMPLES : next_slot;
        word.pressure = PRESSURE_W'(window_sum / count);
        word.full     = window_filled;
        expected_averages.push_back(word);
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        else if (mismatches == REPORT_LIMIT + 1)
            $display("%0t: further mismatches not shown", $time);
    endtask

    // Every handshake is sampled at the rising edge, before the bench drives new values.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            scale_q       = SCALE_RESET;
            intercept_q   = INTERCEPT_RESET;
            zero_q        = ZERO_RESET;
            next_slot     = 0;
            window_filled = 1'b0;
            window_sum    = 0;
            expected_averages.delete();
            pending <= 0;
        end else begin
            // Register writes; an index past the list is dropped.
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_SCALE:     scale_q     = cfg.data[SCALE_W-1:0];
                    REG_INTERCEPT: intercept_q = cfg.data[PRESSURE_W-1:0];
                    REG_ZERO:      zero_q      = cfg.data[PRESSURE_W-1:0];
                    default: ;
                endcase
            end

            if (samples.valid && samples.ready)
                record_sample(samples.raw_millivolts);

            // Each accepted average word is matched against the oldest prediction.
            if (averages.valid && averages.ready) begin
                if (expected_averages.size() == 0) begin
                    report_mismatch("unexpected average word, pressure", 0,
                                    averages.filtered_pressure);
                end else begin
                    oldest = expected_averages.pop_front();
                    compared++;
                    if (averages.filtered_pressure !== oldest.pressure)
                        report_mismatch("filtered_pressure", oldest.pressure,
                                        averages.filtered_pressure);
                    if (averages.window_full !== oldest.full)
                        report_mismatch("window_full", oldest.full, averages.window_full);
                end
            end
            pending <= expected_averages.size();
        end
    end

endmodule

@@ bench/tb_pressure_sample_averager_unit.sv @@
// Testbench top for the pressure sample averager: clock, reset, reading and register stimulus,
// random back-pressure and the verdict. Depends on psa_pkg, psa_if and psa_average_checker.
`timescale 1ns / 1ps

module tb_pressure_sample_averager_unit;
    import psa_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int RANDOM_PHASES = 12;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 60;

    typedef enum {SET_TYPICAL, SET_ANY, SET_EDGES} setting_kind_e;

    logic clk;
    logic rst_n;

    psa_in_if  samples_ch ();
    psa_cfg_if cfg_ch ();
    psa_out_if averages_ch ();

    int fail_count;
    int pending;
    int results_checked;
    int clipped_samples;

    int samples_sent     = 0;
    int settings_applied = 0;
    int idle_cycles      = 0;
    bit source_steady    = 1'b1;
    bit sink_steady      = 1'b1;

    pressure_sample_averager_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples_ch),
        .cfg      (cfg_ch),
        .averages (averages_ch)
    );

    psa_average_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .samples         (samples_ch),
        .cfg             (cfg_ch),
        .averages        (averages_ch),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .clipped_samples (clipped_samples)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Uniform readings, slow drifts, rail values and single-bit patterns.
    function automatic logic [MV_W-1:0] next_reading(input logic [MV_W-1:0] prev);
        int r;
        int v;
        r = $urandom_range(9);
        if (r < 6) begin
            v = $urandom_range(4095);
        end else if (r < 8) begin
            v = int'(prev) + int'($urandom_range(128)) - 64;
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
        end else if (r == 8) begin
            v = $urandom_range(1) ? 4095 : 0;
        end else begin
            v = 1 << $urandom_range(MV_W - 1);
        end
        return MV_W'(v);
    endfunction

    // Offers one reading word and holds it until taken; valid stays up unless a gap follows.
    task automatic drive_sample(input logic [MV_W-1:0] mv);
        int gap;
        samples_ch.valid          <= 1'b1;
        samples_ch.raw_millivolts <= mv;
        do @(posedge clk); while (!samples_ch.ready);
        samples_sent++;
        gap = source_steady ? 0 : idle_length();
        if (gap > 0) begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering readings and waits until every predicted average has arrived.
    task automatic end_phase();
        samples_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Writes all three registers plus one write to the unused index, back to back.
    task automatic write_settings(input logic [CFG_DATA_W-1:0] scale_word,
                                  input logic [CFG_DATA_W-1:0] intercept_word,
                                  input logic [CFG_DATA_W-1:0] zero_word);
        logic [REG_IDX_W-1:0]  reg_sel  [4];
        logic [CFG_DATA_W-1:0] reg_word [4];
        reg_sel  = '{REG_SCALE, REG_UNUSED, REG_INTERCEPT, REG_ZERO};
        reg_word = '{scale_word, CFG_DATA_W'($urandom), intercept_word, zero_word};
        for (int i = 0; i < 4; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= reg_sel[i];
            cfg_ch.data  <= reg_word[i];
            do @(posedge clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        settings_applied++;
    endtask

    // Picks a register setting; the unused top bits of the 16-bit registers carry noise.
    task automatic apply_random_settings(input setting_kind_e kind);
        int scale_v;
        int intercept_v;
        int zero_v;
        int kpa_edges [3];
        int scale_edges [4];
        kpa_edges   = '{-32768, 32767, 0};
        scale_edges = '{0, 1, 65536, 1048575};
        case (kind)
            SET_TYPICAL: begin
                scale_v     = 59652 + int'($urandom_range(16000)) - 8000;
                intercept_v = int'($urandom_range(600)) - 300;
                zero_v      = int'($urandom_range(4000)) - 2000;
            end
            SET_EDGES: begin
                scale_v     = scale_edges[$urandom_range(3)];
                intercept_v = kpa_edges[$urandom_range(2)];
                zero_v      = kpa_edges[$urandom_range(2)];
            end
            default: begin
                scale_v     = $urandom;
                intercept_v = $urandom;
                zero_v      = $urandom;
            end
        endcase
        write_settings(SCALE_W'(scale_v),
                       {4'($urandom), PRESSURE_W'(intercept_v)},
                       {4'($urandom), PRESSURE_W'(zero_v)});
    endtask

    // Random back-pressure on the average channel.
    initial begin
        int hold;
        hold = 0;
        averages_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                averages_ch.ready <= 1'b0;
                hold--;
            end else begin
                averages_ch.ready <= 1'b1;
                if (!sink_steady)
                    hold = idle_length();
            end
        end
    end

    // Watchdog: a long stretch with no word moving on any channel ends the run.
    always @(posedge clk) begin
        if ((samples_ch.valid && samples_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
                || (averages_ch.valid && averages_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [MV_W-1:0] reading;
        int              phase_items;
        int              pace;
        logic [MV_W-1:0] reset_readings [10];
        logic [MV_W-1:0] offset_readings [6];
        reset_readings  = '{12'd0, 12'd4095, 12'd1, 12'd2048, 12'hAAA,
                            12'h555, 12'd4094, 12'd100, 12'd4095, 12'd0};
        offset_readings = '{12'd0, 12'd1, 12'd4095, 12'd3, 12'd2046, 12'd2049};

        rst_n                     = 1'b0;
        samples_ch.valid          = 1'b0;
        samples_ch.raw_millivolts = '0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.index              = '0;
        cfg_ch.data               = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: fill the window, then overwrite its oldest entries.
        foreach (reset_readings[i])
            drive_sample(reset_readings[i]);
        end_phase();

        // Largest gain with both offsets at the negative rail: clips high.
        write_settings(20'hFFFFF, 20'hF8000, 20'h08000);
        drive_sample(12'd4095);
        drive_sample(12'd0);
        end_phase();

        // Zero gain with both offsets at the positive rail: clips low.
        write_settings(20'h00000, 20'h07FFF, 20'hA7FFF);
        drive_sample(12'd4095);
        drive_sample(12'd0);
        drive_sample(12'd2048);
        end_phase();

        // Unity gain shifted around zero: averages of mixed sign and odd sums.
        write_settings(20'd65536, 20'd2000, 20'd47);
        foreach (offset_readings[i])
            drive_sample(offset_readings[i]);
        end_phase();

        // Random phases, each with its own setting and pacing, drained before the next.
        reading = '0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0)
                apply_random_settings(SET_TYPICAL);
            else if (phase == RANDOM_PHASES - 1)
                apply_random_settings(SET_EDGES);
            else
                apply_random_settings(setting_kind_e'($urandom_range(2)));
            pace          = $urandom_range(3);
            source_steady = (pace & 1) != 0;
            sink_steady   = (pace & 2) != 0;
            phase_items   = $urandom_range(200, 120);
            for (int n = 0; n < phase_items; n++) begin
                reading = next_reading(reading);
                drive_sample(reading);
            end
            end_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d readings under %0d register settings; %0d averages compared.",
                 samples_sent, settings_applied, results_checked);
        $display("%0d samples clipped at the pressure limits; %0d mismatches.",
                 clipped_samples, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
